/* hw/rtl/assert_macros.svh */
// Assertion helpers for the checker file bnss_chk.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define BNSS_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition never holds on a clock edge outside reset.
`define BNSS_NEVER(lbl, clk, rst_n, cond, msg) \
  `BNSS_ASSERT(lbl, clk, rst_n, !(cond), msg)

`endif

/* hw/rtl/bnss_pkg.sv */
package bnss_pkg;

  localparam int FIRST_SLAVE  = 0;
  localparam int SLAVE_IDS    = 128;
  localparam int INFO_SLOTS   = 16;
  localparam int SCAN_RETRIES = 3;

  localparam int IDX_W   = (SLAVE_IDS > 1) ? $clog2(SLAVE_IDS) : 1;
  localparam int SLOT_W  = (INFO_SLOTS > 1) ? $clog2(INFO_SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLAVE_IDS + 1);
  localparam int CFG_IDX_W = 1;

  localparam logic [7:0] FIRST_ID    = 8'(FIRST_SLAVE);
  localparam logic [7:0] LAST_ID     = 8'(FIRST_SLAVE + SLAVE_IDS - 1);
  localparam logic [7:0] ID_LIMIT    = 8'd128;
  localparam logic [7:0] NIBBLE_MASK = 8'h0f;
  localparam logic [7:0] DISABLED    = 8'hff;
  localparam logic [7:0] ENTRY_INIT  = 8'(255 - SCAN_RETRIES);
  localparam logic [7:0] SLOT_LIMIT  = 8'(INFO_SLOTS);
  localparam logic [7:0] NODE_ID_RESET = 8'hff;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;
  localparam logic [15:0] COUNT_ZERO    = 16'h0000;
  localparam logic [15:0] COUNT_MAX     = 16'hffff;

  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'b1;

  localparam logic [2:0] OP_POLL      = 3'd0;
  localparam logic [2:0] OP_ACK       = 3'd1;
  localparam logic [2:0] OP_RECONNECT = 3'd2;
  localparam logic [2:0] OP_BUS_ERROR = 3'd3;
  localparam logic [2:0] OP_QUERY     = 3'd4;

  localparam logic [2:0] ACT_NONE     = 3'd0;
  localparam logic [2:0] ACT_PING     = 3'd1;
  localparam logic [2:0] ACT_RESEND   = 3'd2;
  localparam logic [2:0] ACT_RECORDED = 3'd3;
  localparam logic [2:0] ACT_FAILED   = 3'd4;

  localparam logic [2:0] QS_OK        = 3'd0;
  localparam logic [2:0] QS_NOT_CFG   = 3'd1;
  localparam logic [2:0] QS_NOT_MSTR  = 3'd2;
  localparam logic [2:0] QS_RANGE     = 3'd3;
  localparam logic [2:0] QS_NOT_AVAIL = 3'd4;

  localparam logic [1:0] BUS_RUN   = 2'd0;
  localparam logic [1:0] BUS_PANIC = 2'd1;
  localparam logic [1:0] BUS_OFF   = 2'd2;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [7:0]  ack_sender;
    logic        ack_is_retry;
    logic [63:0] ack_data;
    logic [7:0]  query_slave;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  target_slave;
    logic [3:0]  slot;
    logic        slots_full;
    logic        scan_complete;
    logic [1:0]  bus_state;
    logic [2:0]  query_status;
    logic [63:0] query_data;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_PROBE,
    S_BUMP,
    S_PONG,
    S_FAIL,
    S_CHECK,
    S_QENT,
    S_QINFO,
    S_REPLY
  } state_t;

  typedef struct packed {
    logic load;
    logic tick;
    logic advance;
    logic ping;
    logic resend;
    logic fail;
    logic bump;
    logic pong;
    logic check;
    logic set_off;
    logic clear;
    logic qpre;
    logic qna;
    logic qdata;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic [2:0] op;
    logic       waiting;
    logic       master;
    logic       off;
    logic       scan_done;
    logic       tmo;
    logic       match;
    logic       retry;
    logic       pending_hit;
    logic       q_pre_ok;
    logic       q_avail;
  } stat_t;

endpackage

/* hw/rtl/bnss_ram.sv */
module bnss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* hw/rtl/bnss_ctrl.sv */
module bnss_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  bnss_pkg::stat_t stat,
  output bnss_pkg::cmd_t  cmd,
  output logic           busy
);

  bnss_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bnss_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bnss_pkg::S_IDLE: begin
        if (start) begin
          state_nxt = bnss_pkg::S_DECODE;
        end
      end
      bnss_pkg::S_DECODE: begin
        case (stat.op)
          bnss_pkg::OP_POLL: begin
            if (stat.waiting) begin
              state_nxt = (!stat.master || stat.off || stat.tmo) ?
                          bnss_pkg::S_FAIL : bnss_pkg::S_REPLY;
            end else if (stat.master && !stat.scan_done) begin
              state_nxt = bnss_pkg::S_PROBE;
            end else begin
              state_nxt = bnss_pkg::S_REPLY;
            end
          end
          bnss_pkg::OP_ACK: begin
            if (!stat.waiting) begin
              state_nxt = bnss_pkg::S_REPLY;
            end else if (!stat.master || stat.off) begin
              state_nxt = bnss_pkg::S_FAIL;
            end else if (stat.match && !stat.retry) begin
              state_nxt = bnss_pkg::S_PONG;
            end else begin
              state_nxt = bnss_pkg::S_REPLY;
            end
          end
          bnss_pkg::OP_BUS_ERROR: begin
            state_nxt = stat.waiting ? bnss_pkg::S_FAIL : bnss_pkg::S_REPLY;
          end
          bnss_pkg::OP_QUERY: begin
            state_nxt = stat.q_pre_ok ? bnss_pkg::S_QENT : bnss_pkg::S_REPLY;
          end
          default: begin
            state_nxt = bnss_pkg::S_REPLY;
          end
        endcase
      end
      bnss_pkg::S_PROBE: begin
        state_nxt = stat.pending_hit ? bnss_pkg::S_BUMP : bnss_pkg::S_CHECK;
      end
      bnss_pkg::S_BUMP: begin
        state_nxt = stat.off ? bnss_pkg::S_FAIL : bnss_pkg::S_REPLY;
      end
      bnss_pkg::S_PONG: begin
        state_nxt = bnss_pkg::S_CHECK;
      end
      bnss_pkg::S_FAIL: begin
        state_nxt = bnss_pkg::S_CHECK;
      end
      bnss_pkg::S_CHECK: begin
        state_nxt = bnss_pkg::S_REPLY;
      end
      bnss_pkg::S_QENT: begin
        state_nxt = stat.q_avail ? bnss_pkg::S_QINFO : bnss_pkg::S_REPLY;
      end
      bnss_pkg::S_QINFO: begin
        state_nxt = bnss_pkg::S_REPLY;
      end
      bnss_pkg::S_REPLY: begin
        state_nxt = bnss_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bnss_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state_r)
      bnss_pkg::S_IDLE: begin
        cmd.load = start;
      end
      bnss_pkg::S_DECODE: begin
        case (stat.op)
          bnss_pkg::OP_POLL: begin
            if (stat.waiting) begin
              cmd.tick = stat.master && !stat.off && !stat.tmo;
            end else begin
              cmd.advance = stat.master && !stat.scan_done;
            end
          end
          bnss_pkg::OP_ACK: begin
            cmd.resend = stat.waiting && stat.master && !stat.off &&
                         stat.match && stat.retry;
          end
          bnss_pkg::OP_RECONNECT: begin
            cmd.clear = 1'b1;
          end
          bnss_pkg::OP_BUS_ERROR: begin
            cmd.set_off = 1'b1;
          end
          bnss_pkg::OP_QUERY: begin
            cmd.qpre = !stat.q_pre_ok;
          end
          default: begin
            cmd = '0;
          end
        endcase
      end
      bnss_pkg::S_BUMP: begin
        cmd.bump = 1'b1;
        cmd.ping = !stat.off;
      end
      bnss_pkg::S_PONG: begin
        cmd.pong = 1'b1;
      end
      bnss_pkg::S_FAIL: begin
        cmd.fail = 1'b1;
      end
      bnss_pkg::S_CHECK: begin
        cmd.check = 1'b1;
      end
      bnss_pkg::S_QENT: begin
        cmd.qna = !stat.q_avail;
      end
      bnss_pkg::S_QINFO: begin
        cmd.qdata = 1'b1;
      end
      bnss_pkg::S_REPLY: begin
        cmd.emit = 1'b1;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  assign busy = (state_r != bnss_pkg::S_IDLE);

endmodule

/* hw/rtl/bnss_dp.sv */
module bnss_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bnss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_wdata,
  input  bnss_pkg::in_item_t                  in_item,
  input  bnss_pkg::cmd_t                      cmd,
  output bnss_pkg::stat_t                     stat,
  output logic                                out_strobe,
  output bnss_pkg::out_item_t                 out_item
);

  localparam int IDX_W  = bnss_pkg::IDX_W;
  localparam int SLOT_W = bnss_pkg::SLOT_W;
  localparam int CNT_W  = bnss_pkg::CNT_W;
  localparam int NS     = bnss_pkg::SLAVE_IDS;
  localparam int NI     = bnss_pkg::INFO_SLOTS;
  localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(NS);

  logic [7:0]          node_id_r, node_id_nxt;
  logic [15:0]         timeout_r, timeout_nxt;
  bnss_pkg::in_item_t  item_r, item_nxt;
  logic [7:0]          search_r, search_nxt;
  logic                waiting_r, waiting_nxt;
  logic [15:0]         wcnt_r, wcnt_nxt;
  logic                scan_done_r, scan_done_nxt;
  logic                panic_r, panic_nxt;
  logic                off_r, off_nxt;
  logic [NS-1:0]       valid_r, valid_nxt;
  logic [NS-1:0]       pending_r, pending_nxt;
  logic [CNT_W-1:0]    pcnt_r, pcnt_nxt;
  logic [NI-1:0]       used_r, used_nxt;
  bnss_pkg::out_item_t res_r, res_nxt;
  bnss_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_strobe_r, out_strobe_nxt;

  logic [IDX_W-1:0]  search_idx;
  logic [IDX_W-1:0]  q_idx;
  logic [IDX_W-1:0]  node_idx;
  logic [IDX_W-1:0]  ent_raddr;
  logic [7:0]        ent_q;
  logic [7:0]        ent_cur;
  logic [7:0]        bump_val;
  logic [7:0]        ent_wdata;
  logic              ent_we;
  logic [SLOT_W-1:0] slot_sel;
  logic              slot_found;
  logic [63:0]       info_q;
  logic              info_we;
  logic [7:0]        adv1;
  logic [7:0]        adv2;
  logic [7:0]        search_adv;
  logic              master;
  logic              node_in;
  logic              done_cond;
  logic [15:0]       limit;
  logic [15:0]       wcnt_inc;
  logic              q_in_range;
  logic [2:0]        q_pre;

  assign search_idx = IDX_W'(search_r - bnss_pkg::FIRST_ID);
  assign q_idx      = IDX_W'(item_r.query_slave - bnss_pkg::FIRST_ID);
  assign node_idx   = IDX_W'(node_id_r - bnss_pkg::FIRST_ID);
  assign ent_raddr  = (item_r.opcode == bnss_pkg::OP_QUERY) ? q_idx : search_idx;
  assign ent_cur    = valid_r[ent_raddr] ? ent_q : bnss_pkg::ENTRY_INIT;
  assign bump_val   = ent_cur + 8'd1;

  always_comb begin
    slot_sel = '0;
    for (int i = NI - 1; i >= 0; i--) begin
      if (!used_r[i]) begin
        slot_sel = SLOT_W'(i);
      end
    end
  end

  assign slot_found = !(&used_r);
  assign ent_we     = cmd.bump || cmd.pong;
  assign ent_wdata  = cmd.bump ? bump_val :
                      (slot_found ? 8'(slot_sel) : bnss_pkg::DISABLED);
  assign info_we    = cmd.pong && slot_found;

  bnss_ram #(.WIDTH(8), .DEPTH(NS)) u_entry_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (search_idx),
    .wdata (ent_wdata),
    .raddr (ent_raddr),
    .rdata (ent_q)
  );

  bnss_ram #(.WIDTH(64), .DEPTH(NI)) u_info_ram (
    .clk   (clk),
    .we    (info_we),
    .waddr (slot_sel),
    .wdata (item_r.ack_data),
    .raddr (ent_cur[SLOT_W-1:0]),
    .rdata (info_q)
  );

  assign adv1 = (search_r >= bnss_pkg::LAST_ID || search_r < bnss_pkg::FIRST_ID) ?
                bnss_pkg::FIRST_ID : search_r + 8'd1;
  assign adv2 = (adv1 >= bnss_pkg::LAST_ID || adv1 < bnss_pkg::FIRST_ID) ?
                bnss_pkg::FIRST_ID : adv1 + 8'd1;
  assign search_adv = (adv1 == node_id_r) ? adv2 : adv1;

  assign master    = (node_id_r < bnss_pkg::ID_LIMIT) &&
                     ((node_id_r & bnss_pkg::NIBBLE_MASK) == 8'd0);
  assign node_in   = (node_id_r >= bnss_pkg::FIRST_ID) && (node_id_r <= bnss_pkg::LAST_ID);
  assign done_cond = (pcnt_r == '0) ||
                     ((pcnt_r == CNT_ONE) && node_in && pending_r[node_idx]);
  assign limit     = (timeout_r == bnss_pkg::COUNT_ZERO) ? 16'd1 : timeout_r;
  assign wcnt_inc  = (wcnt_r == bnss_pkg::COUNT_MAX) ? wcnt_r : wcnt_r + 16'd1;

  assign q_in_range = (item_r.query_slave >= bnss_pkg::FIRST_ID) &&
                      (item_r.query_slave <= bnss_pkg::LAST_ID);

  always_comb begin
    if (node_id_r >= bnss_pkg::ID_LIMIT) begin
      q_pre = bnss_pkg::QS_NOT_CFG;
    end else if ((node_id_r & bnss_pkg::NIBBLE_MASK) != 8'd0) begin
      q_pre = bnss_pkg::QS_NOT_MSTR;
    end else if (!q_in_range) begin
      q_pre = bnss_pkg::QS_RANGE;
    end else begin
      q_pre = bnss_pkg::QS_OK;
    end
  end

  always_comb begin
    stat.op          = item_r.opcode;
    stat.waiting     = waiting_r;
    stat.master      = master;
    stat.off         = off_r;
    stat.scan_done   = scan_done_r;
    stat.tmo         = (wcnt_inc >= limit);
    stat.match       = (item_r.ack_sender == search_r);
    stat.retry       = item_r.ack_is_retry;
    stat.pending_hit = pending_r[search_idx];
    stat.q_pre_ok    = (q_pre == bnss_pkg::QS_OK);
    stat.q_avail     = (ent_cur < bnss_pkg::ID_LIMIT) && (ent_cur < bnss_pkg::SLOT_LIMIT);
  end

  always_comb begin
    node_id_nxt    = node_id_r;
    timeout_nxt    = timeout_r;
    item_nxt       = item_r;
    search_nxt     = search_r;
    waiting_nxt    = waiting_r;
    wcnt_nxt       = wcnt_r;
    scan_done_nxt  = scan_done_r;
    panic_nxt      = panic_r;
    off_nxt        = off_r;
    valid_nxt      = valid_r;
    pending_nxt    = pending_r;
    pcnt_nxt       = pcnt_r;
    used_nxt       = used_r;
    res_nxt        = res_r;
    out_item_nxt   = out_item_r;
    out_strobe_nxt = cmd.emit;

    if (cfg_we) begin
      case (cfg_index)
        bnss_pkg::CFG_NODE_ID: node_id_nxt = cfg_wdata[7:0];
        bnss_pkg::CFG_TIMEOUT: timeout_nxt = cfg_wdata;
        default: node_id_nxt = node_id_r;
      endcase
    end

    if (cmd.load) begin
      item_nxt = in_item;
      res_nxt  = '0;
    end
    if (cmd.tick) begin
      wcnt_nxt = wcnt_inc;
    end
    if (cmd.advance) begin
      search_nxt = search_adv;
    end
    if (cmd.bump) begin
      valid_nxt[search_idx] = 1'b1;
      if (bump_val == bnss_pkg::DISABLED) begin
        pending_nxt[search_idx] = 1'b0;
        pcnt_nxt = pcnt_r - CNT_ONE;
      end
    end
    if (cmd.ping) begin
      waiting_nxt          = 1'b1;
      wcnt_nxt             = bnss_pkg::COUNT_ZERO;
      res_nxt.action       = bnss_pkg::ACT_PING;
      res_nxt.target_slave = search_r;
    end
    if (cmd.resend) begin
      wcnt_nxt             = bnss_pkg::COUNT_ZERO;
      res_nxt.action       = bnss_pkg::ACT_RESEND;
      res_nxt.target_slave = search_r;
    end
    if (cmd.pong) begin
      res_nxt.action        = bnss_pkg::ACT_RECORDED;
      res_nxt.target_slave  = search_r;
      valid_nxt[search_idx] = 1'b1;
      if (slot_found) begin
        res_nxt.slot       = 4'(slot_sel);
        used_nxt[slot_sel] = (item_r.ack_data[7:0] != 8'd0);
      end else begin
        res_nxt.slots_full = 1'b1;
      end
      if (pending_r[search_idx]) begin
        pending_nxt[search_idx] = 1'b0;
        pcnt_nxt = pcnt_r - CNT_ONE;
      end
      waiting_nxt = 1'b0;
      wcnt_nxt    = bnss_pkg::COUNT_ZERO;
    end
    if (cmd.fail) begin
      res_nxt.action       = bnss_pkg::ACT_FAILED;
      res_nxt.target_slave = search_r;
      waiting_nxt          = 1'b0;
      wcnt_nxt             = bnss_pkg::COUNT_ZERO;
    end
    if (cmd.check && done_cond) begin
      scan_done_nxt = 1'b1;
    end
    if (cmd.set_off) begin
      panic_nxt = 1'b1;
      off_nxt   = 1'b1;
    end
    if (cmd.clear) begin
      scan_done_nxt = 1'b0;
      search_nxt    = bnss_pkg::DISABLED;
      waiting_nxt   = 1'b0;
      wcnt_nxt      = bnss_pkg::COUNT_ZERO;
      valid_nxt     = '0;
      pending_nxt   = '1;
      pcnt_nxt      = CNT_FULL;
      used_nxt      = '0;
    end
    if (cmd.qpre) begin
      res_nxt.query_status = q_pre;
    end
    if (cmd.qna) begin
      res_nxt.query_status = bnss_pkg::QS_NOT_AVAIL;
    end
    if (cmd.qdata) begin
      res_nxt.query_data = info_q;
    end
    if (cmd.emit) begin
      out_item_nxt               = res_r;
      out_item_nxt.scan_complete = scan_done_r;
      out_item_nxt.bus_state     = off_r ? bnss_pkg::BUS_OFF :
                                   (panic_r ? bnss_pkg::BUS_PANIC : bnss_pkg::BUS_RUN);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_id_r    <= bnss_pkg::NODE_ID_RESET;
      timeout_r    <= bnss_pkg::TIMEOUT_RESET;
      search_r     <= bnss_pkg::DISABLED;
      waiting_r    <= 1'b0;
      wcnt_r       <= bnss_pkg::COUNT_ZERO;
      scan_done_r  <= 1'b0;
      panic_r      <= 1'b0;
      off_r        <= 1'b0;
      valid_r      <= '0;
      pending_r    <= '1;
      pcnt_r       <= CNT_FULL;
      used_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      node_id_r    <= node_id_nxt;
      timeout_r    <= timeout_nxt;
      search_r     <= search_nxt;
      waiting_r    <= waiting_nxt;
      wcnt_r       <= wcnt_nxt;
      scan_done_r  <= scan_done_nxt;
      panic_r      <= panic_nxt;
      off_r        <= off_nxt;
      valid_r      <= valid_nxt;
      pending_r    <= pending_nxt;
      pcnt_r       <= pcnt_nxt;
      used_r       <= used_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    res_r      <= res_nxt;
    out_item_r <= out_item_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

/* hw/rtl/bus_node_slave_scan_engine.sv */
// Node scanner of a bus master. A word is taken when start is high while busy
// is low; the block then stays busy until its single result word appears on
// out_item with out_strobe high for one cycle. The steps that the sequencer
// walks are set by the opcode: a ping walks a slave table read and update, a
// pong writes the info store and runs the finished check, and a query reads
// the slave table and then the info store, each read through a registered
// memory output. busy falls in the cycle the result is shown, so the next
// word may be taken right then. There is no stall from the receiver: a
// result must be taken when strobed. Configuration writes on cfg_we take
// effect at once and belong to idle time.
module bus_node_slave_scan_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bnss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]                    cfg_wdata,
  input  logic                           start,
  output logic                           busy,
  input  bnss_pkg::in_item_t             in_item,
  output logic                           out_strobe,
  output bnss_pkg::out_item_t            out_item
);

  bnss_pkg::cmd_t  cmd;
  bnss_pkg::stat_t stat;

  bnss_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  bnss_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

/* hw/rtl/bnss_chk.sv */
`include "assert_macros.svh"

module bnss_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_strobe,
  input bnss_pkg::out_item_t out_item
);

  logic full_no_pong;
  logic data_no_ok;

  assign full_no_pong = out_strobe && out_item.slots_full &&
                        (out_item.action != bnss_pkg::ACT_RECORDED);
  assign data_no_ok   = out_strobe && (out_item.query_status != bnss_pkg::QS_OK) &&
                        (out_item.query_data != 64'd0);

  `BNSS_ASSERT(a_strobe_single, clk, rst_n, out_strobe |=> !out_strobe, "Strobe too long.")
  `BNSS_ASSERT(a_busy_after_take, clk, rst_n, (start && !busy) |=> busy, "Busy did not rise.")
  `BNSS_ASSERT(a_idle_at_result, clk, rst_n, out_strobe |-> !busy, "Busy at a result.")
  `BNSS_NEVER(a_full_only_pong, clk, rst_n, full_no_pong, "Slots full without a record.")
  `BNSS_NEVER(a_qdata_only_ok, clk, rst_n, data_no_ok, "Query data with a failing status.")

endmodule

bind bus_node_slave_scan_engine bnss_chk u_bnss_chk (.*);

/* tb/tb_bus_node_slave_scan_engine.sv */
`timescale 1ns / 100ps

module tb_bus_node_slave_scan_engine;
  import bnss_pkg::*;

  localparam logic [2:0] OP_UNUSED_LO = 3'd5;
  localparam logic [2:0] OP_UNUSED_HI = 3'd7;

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_NODE_ID;
  logic [15:0]          cfg_wdata = 16'h0000;
  logic                 start = 1'b0;
  logic                 busy;
  in_item_t             in_item = '0;
  logic                 out_strobe;
  out_item_t            out_item;

  bus_node_slave_scan_engine DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

  logic [7:0]  own_id;
  logic [15:0] poll_limit;
  logic [7:0]  slave_tab [SLAVE_IDS];
  logic [63:0] info_tab [INFO_SLOTS];
  logic [7:0]  probe_id;
  logic        awaiting_ack;
  logic [15:0] ack_wait;
  logic        scan_over;
  logic        panic_seen;
  logic        bus_off;

  out_item_t pending_results [$];
  int        mismatch_count = 0;
  int        send_idle_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("tb_bus_node_slave_scan_engine: FAIL");
    $finish;
  end

  function automatic logic own_is_master();
    return (own_id < ID_LIMIT) && ((own_id & NIBBLE_MASK) == 8'h00);
  endfunction

  function automatic void clear_scan_tables();
    int i;
    scan_over = 1'b0;
    probe_id = DISABLED;
    awaiting_ack = 1'b0;
    ack_wait = COUNT_ZERO;
    for (i = 0; i < SLAVE_IDS; i++) slave_tab[i] = ENTRY_INIT;
    for (i = 0; i < INFO_SLOTS; i++) info_tab[i] = 64'h0;
  endfunction

  function automatic void reset_scan_model();
    own_id = NODE_ID_RESET;
    poll_limit = TIMEOUT_RESET;
    panic_seen = 1'b0;
    bus_off = 1'b0;
    clear_scan_tables();
  endfunction

  function automatic void run_finish_check();
    int   i;
    logic done;
    done = 1'b1;
    for (i = 0; i < SLAVE_IDS; i++) begin
      if (slave_tab[i] >= ID_LIMIT && slave_tab[i] != DISABLED &&
          (i + FIRST_SLAVE) != int'(own_id)) done = 1'b0;
    end
    if (done) scan_over = 1'b1;
  endfunction

  function automatic void close_attempt();
    awaiting_ack = 1'b0;
    ack_wait = COUNT_ZERO;
    run_finish_check();
  endfunction

  function automatic void mark_failed(inout out_item_t r);
    r.action = ACT_FAILED;
    r.target_slave = probe_id;
    close_attempt();
  endfunction

  function automatic out_item_t predict_scan_result(in_item_t w);
    out_item_t   r;
    logic [15:0] lim;
    logic [7:0]  idx8;
    logic [7:0]  e;
    logic        moved;
    int          k;
    int          hit;
    r = '0;
    lim = (poll_limit == COUNT_ZERO) ? 16'd1 : poll_limit;
    case (w.opcode)
      OP_POLL: begin
        if (awaiting_ack) begin
          if (!own_is_master() || bus_off) begin
            mark_failed(r);
          end else begin
            if (ack_wait != COUNT_MAX) ack_wait = ack_wait + 16'd1;
            if (ack_wait >= lim) mark_failed(r);
          end
        end else if (own_is_master() && !scan_over) begin
          moved = 1'b0;
          for (k = 0; k < 2; k++) begin
            if (!moved) begin
              if (probe_id < FIRST_ID || probe_id >= LAST_ID) probe_id = FIRST_ID - 8'd1;
              probe_id = probe_id + 8'd1;
              if (probe_id != own_id) moved = 1'b1;
            end
          end
          idx8 = probe_id - FIRST_ID;
          if (int'(idx8) < SLAVE_IDS && slave_tab[idx8] >= ID_LIMIT &&
              slave_tab[idx8] != DISABLED) begin
            slave_tab[idx8] = slave_tab[idx8] + 8'd1;
            if (bus_off) begin
              mark_failed(r);
            end else begin
              r.action = ACT_PING;
              r.target_slave = probe_id;
              awaiting_ack = 1'b1;
              ack_wait = COUNT_ZERO;
            end
          end else begin
            run_finish_check();
          end
        end
      end
      OP_ACK: begin
        if (awaiting_ack) begin
          if (!own_is_master() || bus_off) begin
            mark_failed(r);
          end else if (w.ack_sender == probe_id) begin
            if (w.ack_is_retry) begin
              r.action = ACT_RESEND;
              r.target_slave = probe_id;
              ack_wait = COUNT_ZERO;
            end else begin
              idx8 = probe_id - FIRST_ID;
              r.action = ACT_RECORDED;
              r.target_slave = probe_id;
              hit = -1;
              for (k = 0; k < INFO_SLOTS; k++) begin
                if (hit < 0 && info_tab[k][7:0] == 8'h00) hit = k;
              end
              if (hit >= 0) begin
                info_tab[hit] = w.ack_data;
                if (int'(idx8) < SLAVE_IDS) slave_tab[idx8] = 8'(hit);
                r.slot = 4'(hit);
              end else begin
                if (int'(idx8) < SLAVE_IDS) slave_tab[idx8] = DISABLED;
                r.slots_full = 1'b1;
              end
              close_attempt();
            end
          end
        end
      end
      OP_RECONNECT: begin
        clear_scan_tables();
      end
      OP_BUS_ERROR: begin
        panic_seen = 1'b1;
        bus_off = 1'b1;
        if (awaiting_ack) mark_failed(r);
      end
      OP_QUERY: begin
        if (own_id >= ID_LIMIT) begin
          r.query_status = QS_NOT_CFG;
        end else if ((own_id & NIBBLE_MASK) != 8'h00) begin
          r.query_status = QS_NOT_MSTR;
        end else if (w.query_slave < FIRST_ID || w.query_slave > LAST_ID) begin
          r.query_status = QS_RANGE;
        end else begin
          e = slave_tab[w.query_slave - FIRST_ID];
          if (e >= ID_LIMIT || e >= SLOT_LIMIT) begin
            r.query_status = QS_NOT_AVAIL;
          end else begin
            r.query_status = QS_OK;
            r.query_data = info_tab[e];
          end
        end
      end
      default: begin
      end
    endcase
    r.scan_complete = scan_over;
    r.bus_state = bus_off ? BUS_OFF : (panic_seen ? BUS_PANIC : BUS_RUN);
    return r;
  endfunction

  function automatic in_item_t word_of(logic [2:0] op, logic [7:0] sender, logic retry,
                                       logic [63:0] data, logic [7:0] q);
    in_item_t w;
    w.opcode = op;
    w.ack_sender = sender;
    w.ack_is_retry = retry;
    w.ack_data = data;
    w.query_slave = q;
    return w;
  endfunction

  function automatic in_item_t random_word();
    return word_of(3'($urandom_range(7)), 8'($urandom_range(255)), 1'($urandom_range(1)),
                   {$urandom, $urandom}, 8'($urandom_range(255)));
  endfunction

  task automatic report_field(string name, logic [63:0] want, logic [63:0] got);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    mismatch_count++;
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_strobe) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %0h", $time, out_item);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_item.action !== want.action)
          report_field("action", want.action, out_item.action);
        if (out_item.target_slave !== want.target_slave)
          report_field("target_slave", want.target_slave, out_item.target_slave);
        if (out_item.slot !== want.slot)
          report_field("slot", want.slot, out_item.slot);
        if (out_item.slots_full !== want.slots_full)
          report_field("slots_full", want.slots_full, out_item.slots_full);
        if (out_item.scan_complete !== want.scan_complete)
          report_field("scan_complete", want.scan_complete, out_item.scan_complete);
        if (out_item.bus_state !== want.bus_state)
          report_field("bus_state", want.bus_state, out_item.bus_state);
        if (out_item.query_status !== want.query_status)
          report_field("query_status", want.query_status, out_item.query_status);
        if (out_item.query_data !== want.query_data)
          report_field("query_data", want.query_data, out_item.query_data);
      end
    end
  end

  task automatic send_word(in_item_t w);
    int gap;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= w;
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(predict_scan_result(w));
  endtask

  task automatic hold_until_idle();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_NODE_ID) own_id = data[7:0];
    else poll_limit = data;
  endtask

  task automatic set_node(logic [7:0] node);
    hold_until_idle();
    write_reg(CFG_NODE_ID, {8'($urandom_range(255)), node});
  endtask

  task automatic set_phase(logic [7:0] node, logic [15:0] tmo, int idle_pct);
    set_node(node);
    write_reg(CFG_TIMEOUT, tmo);
    send_idle_pct = idle_pct;
  endtask

  task automatic test_unconfigured_node();
    int k;
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h05));
    send_word(word_of(OP_POLL, 8'hff, 1'b1, 64'hffff_ffff_ffff_ffff, 8'hff));
    send_word(word_of(OP_ACK, 8'h00, 1'b0, 64'h1234_5678_9abc_def1, 8'h00));
    for (k = OP_UNUSED_LO; k <= OP_UNUSED_HI; k++)
      send_word(word_of(3'(k), 8'($urandom_range(255)), 1'b1, {$urandom, $urandom}, 8'h80));
    send_word(word_of(OP_RECONNECT, 8'h00, 1'b0, 64'h0, 8'h00));
  endtask

  task automatic test_not_master();
    set_node(8'h13);
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h01));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
  endtask

  task automatic test_ping_and_pong();
    set_phase(8'h00, 16'd2, 0);
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_ACK, 8'h55, 1'b0, 64'h0000_0000_0000_0001, 8'h00));
    send_word(word_of(OP_ACK, 8'h01, 1'b1, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_ACK, 8'h02, 1'b0, 64'hffff_ffff_ffff_ff00, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_ACK, 8'h03, 1'b0, 64'hffff_ffff_ffff_ffff, 8'h00));
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h03));
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h02));
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h7f));
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'hff));
  endtask

  task automatic test_zero_timeout();
    hold_until_idle();
    write_reg(CFG_TIMEOUT, 16'h0000);
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
  endtask

  task automatic test_master_lost_while_waiting();
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    set_node(8'h71);
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    set_node(8'h00);
    send_word(word_of(OP_ACK, probe_id, 1'b0, 64'h0000_0000_0000_00aa, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    set_node(8'h71);
    send_word(word_of(OP_ACK, probe_id, 1'b0, 64'h0000_0000_0000_00bb, 8'h00));
  endtask

  task automatic test_bus_off();
    set_phase(8'h10, 16'd3, 0);
    send_word(word_of(OP_RECONNECT, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_BUS_ERROR, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_QUERY, 8'h00, 1'b0, 64'h0, 8'h01));
    send_word(word_of(OP_RECONNECT, 8'h00, 1'b0, 64'h0, 8'h00));
    send_word(word_of(OP_POLL, 8'h00, 1'b0, 64'h0, 8'h00));
  endtask

  task automatic run_scan_traffic(int count, logic with_bus_errors);
    in_item_t w;
    int       pick;
    int       i;
    for (i = 0; i < count; i++) begin
      w = random_word();
      pick = $urandom_range(99);
      if (with_bus_errors && pick < 2) begin
        w.opcode = OP_BUS_ERROR;
      end else if (awaiting_ack) begin
        if (pick < 55) begin
          w.opcode = OP_ACK;
          w.ack_sender = probe_id;
          w.ack_is_retry = ($urandom_range(99) < 15);
        end else if (pick < 78) begin
          w.opcode = OP_POLL;
        end else if (pick < 86) begin
          w.opcode = OP_ACK;
        end else if (pick < 94) begin
          w.opcode = OP_QUERY;
        end else if (pick < 95) begin
          w.opcode = OP_RECONNECT;
        end else begin
          w.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
      end else begin
        if (scan_over && pick < 40) begin
          w.opcode = OP_RECONNECT;
        end else if (pick < 75) begin
          w.opcode = OP_POLL;
        end else if (pick < 88) begin
          w.opcode = OP_QUERY;
        end else if (pick < 89) begin
          w.opcode = OP_RECONNECT;
        end else if (pick < 95) begin
          w.opcode = OP_ACK;
        end else begin
          w.opcode = 3'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
        end
      end
      if (w.opcode == OP_QUERY && $urandom_range(3) != 0) w.query_slave[7] = 1'b0;
      send_word(w);
      if ($urandom_range(199) == 0) hold_until_idle();
    end
  endtask

  initial begin
    reset_scan_model();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_unconfigured_node();
    test_not_master();
    test_ping_and_pong();
    test_zero_timeout();
    test_master_lost_while_waiting();
    set_phase(8'h10, 16'd3, 0);
    run_scan_traffic(160, 1'b0);
    set_phase(8'h70, 16'd1, 75);
    run_scan_traffic(160, 1'b0);
    set_phase(8'h00, 16'hffff, 30);
    run_scan_traffic(120, 1'b0);
    set_phase(8'h35, 16'd2, 0);
    run_scan_traffic(40, 1'b0);
    set_phase(8'h20, 16'd2, 75);
    run_scan_traffic(160, 1'b0);
    set_phase(8'hff, 16'd4, 30);
    run_scan_traffic(30, 1'b0);
    test_bus_off();
    set_phase(8'h40, 16'd4, 30);
    run_scan_traffic(80, 1'b1);
    hold_until_idle();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("tb_bus_node_slave_scan_engine: PASS");
    end else begin
      $display("tb_bus_node_slave_scan_engine: FAIL");
    end
    $finish;
  end

endmodule
